// ===== rtl/core/urx_pkg.sv =====
// Shared types, constants and helpers for the UART receive oversampler.
// No dependencies; imported by every module under rtl/core.
package urx_pkg;

  localparam int unsigned CountW      = 12;
  localparam int unsigned FrameW      = 10;
  localparam int unsigned ByteW       = 8;

  localparam logic [CountW-1:0] PeriodReset = 12'd208;
  localparam logic [FrameW-1:0] FramePreset = 10'h3FF;
  localparam logic [ByteW-1:0]  PrintLow    = 8'd32;
  localparam logic [ByteW-1:0]  PrintHigh   = 8'd126;

  // One decoded character as it leaves the frame logic.
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] data;
    logic             printable;
  } urx_result_t;

  function automatic logic is_printable(input logic [ByteW-1:0] b);
    is_printable = (b >= PrintLow) && (b <= PrintHigh);
  endfunction

endpackage

// ===== rtl/core/urx_frame.sv =====
// Phase counter, last-level tracker and 10-bit frame shifter.
// Depends on urx_pkg.
module urx_frame
  import urx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              level,
  input  logic [CountW-1:0] bit_period,
  output urx_result_t       result
);

  logic              last_level;
  logic [CountW-1:0] phase_count;
  logic [FrameW-1:0] frame_shifter;

  logic              last_level_next;
  logic [CountW-1:0] phase_count_next;
  logic [FrameW-1:0] frame_shifter_next;
  logic [CountW-1:0] count_base;
  logic [CountW-1:0] count_inc;
  logic [FrameW-1:0] shifted;
  logic              sample;
  logic              emit;

  always_comb begin
    // level change restarts the count before this tick is added
    count_base       = (level != last_level) ? '0 : phase_count;
    count_inc        = count_base + 1'b1;
    phase_count_next = (count_inc == bit_period) ? '0 : count_inc;
    last_level_next  = level;
    sample           = (phase_count_next == (bit_period >> 1));
    shifted          = {level, frame_shifter[FrameW-1:1]};
    emit             = sample && !shifted[0];
    if (emit) begin
      frame_shifter_next = FramePreset;
    end else if (sample) begin
      frame_shifter_next = shifted;
    end else begin
      frame_shifter_next = frame_shifter;
    end
    result.emit      = emit;
    result.data      = shifted[ByteW:1];
    result.printable = is_printable(shifted[ByteW:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b0;
      phase_count   <= '0;
      frame_shifter <= FramePreset;
    end else if (step) begin
      last_level    <= last_level_next;
      phase_count   <= phase_count_next;
      frame_shifter <= frame_shifter_next;
    end
  end

  // start bit never rests at the bottom: it is consumed as soon as it lands
  a_bottom_idle: assert property (@(posedge clk) disable iff (rst)
    frame_shifter[0] == 1'b1)
    else $error("frame bottom bit held a start bit");

  // a level change always leaves the counter at one tick (or zero on wrap)
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && (level != last_level) |=> (phase_count == 12'd1) || (phase_count == 12'd0))
    else $error("phase counter not restarted on level change");

  a_emit_sample: assert property (@(posedge clk) disable iff (rst)
    result.emit |-> sample)
    else $error("byte emitted off the sampling point");

endmodule

// ===== rtl/core/urx_outreg.sv =====
// Result register for decoded characters, with valid/stall handshake.
// Depends on urx_pkg.
module urx_outreg
  import urx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  urx_result_t      result,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ByteW-1:0] data_byte,
  output logic             printable
);

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte <= result.data;
      printable <= result.printable;
    end
  end

endmodule

// ===== rtl/core/uart_rx_oversampler.sv =====
// Top level of the UART receive oversampler (8N1, no stop-bit check).
// Depends on urx_pkg, urx_frame and urx_outreg.
//
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_stall  | line_level
//  out     | source    | out_valid / out_stall| data_byte, printable
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_data (bit_period)
//
// One line sample is taken per cycle unless the input is stalled; a character
// reaches the output through the input register, then the result register.
// Reset (rst, synchronous) sets bit_period to 208, the frame to all ones.
// A pending result stalls the input register only when that register holds
// a sample that itself completes a character; all other samples flow on.
module uart_rx_oversampler
  import urx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              line_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ByteW-1:0]  data_byte,
  output logic              printable,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CountW-1:0] cfg_data
);

  logic [CountW-1:0] bit_period;
  logic              s1_valid;
  logic              s1_level;
  logic              s1_move;
  logic              can_load;
  urx_result_t       result;

  // configuration is always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= PeriodReset;
    end else if (cfg_valid && cfg_ready) begin
      bit_period <= cfg_data;
    end
  end

  // held sample advances unless it completes a character and the result
  // register is still occupied
  assign s1_move  = s1_valid && (!result.emit || can_load);
  assign in_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_level <= line_level;
    end
  end

  urx_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_move),
    .level     (s1_level),
    .bit_period(bit_period),
    .result    (result)
  );

  urx_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_move && result.emit),
    .result   (result),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data_byte(data_byte),
    .printable(printable)
  );

  // stall only ever comes from a held sample waiting on the result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && result.emit && out_valid && out_stall)
    else $error("input stalled without a blocked character");

endmodule

// ===== bench/uart_rx_oversampler_test.sv =====
// Self-checking bench for uart_rx_oversampler: serial line samples in, decoded characters out.
// Depends on urx_pkg and the uart_rx_oversampler RTL; the line model below is self-contained.
module uart_rx_oversampler_test;
  import urx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 200_000;   // watchdog, far above the slowest legal run
  localparam int DrainTicks    = 8;         // two pipeline stages plus margin
  localparam int RandomSamples = 250;
  localparam int LongHold      = 300;       // receiver hold-off used to back the block up

  localparam logic [ByteW-1:0] FirstPrintable = 8'd32;
  localparam logic [ByteW-1:0] LastPrintable  = 8'd126;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             printable;
  } rx_char_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              line_level = 1'b1;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ByteW-1:0]  data_byte;
  logic              printable;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_data  = '0;

  uart_rx_oversampler DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .line_level (line_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_byte  (data_byte),
    .printable  (printable),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line model: our own copy of the receiver state, stepped once per accepted
  // sample. Decoded characters are queued here in arrival order.
  // ---------------------------------------------------------------------------
  logic [CountW-1:0] period_cfg  = PeriodReset;
  logic              prev_level  = 1'b0;
  logic [CountW-1:0] phase       = '0;
  logic [FrameW-1:0] frame       = FramePreset;
  rx_char_t          expected_chars[$];

  function automatic void follow_line(input logic lvl);
    rx_char_t c;
    // an edge on the line restarts the bit timing before this tick counts
    if (lvl != prev_level) begin
      prev_level = lvl;
      phase      = '0;
    end
    phase = phase + 1'b1;            // wraps at 4096 by width
    if (phase == period_cfg)
      phase = '0;
    // mid-bit: shift the level in from the top
    if (phase == (period_cfg >> 1)) begin
      frame = {lvl, frame[FrameW-1:1]};
      // start bit has reached the bottom - character complete, stop bit ignored
      if (!frame[0]) begin
        c.data      = frame[ByteW:1];
        c.printable = (c.data >= FirstPrintable) && (c.data <= LastPrintable);
        expected_chars.push_back(c);
        frame = FramePreset;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers queued line samples, one request per accepted sample.
  // Inputs move on the falling edge; a stalled request is held unchanged.
  // ---------------------------------------------------------------------------
  logic line_samples[$];
  int   samples_queued = 0;
  int   gap_pct        = 0;   // chance of starting an idle burst, in percent
  int   gap_left       = 0;
  bit   sample_taken   = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !sample_taken) begin
      // request still pending - hold valid and payload
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (line_samples.size() > 0) begin
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
        gap_left = $urandom_range(1, 12) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid   <= 1'b1;
        line_level <= line_samples[0];
      end
    end else begin
      in_valid <= 1'b0;
    end
    sample_taken = 0;
  end

  // acceptance at the rising edge drives the line model
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sample_taken = 1;
      void'(line_samples.pop_front());
      follow_line(line_level);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and pushes back on its input.
  // ---------------------------------------------------------------------------
  int stall_pct     = 0;
  int stall_left    = 0;
  bit long_hold_req = 0;

  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      stall_left    = LongHold;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every accepted character against the oldest expected one.
  // ---------------------------------------------------------------------------
  int errors     = 0;

  always @(posedge clk) begin
    rx_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got data_byte=%02h printable=%0b",
                 $time, data_byte, printable);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (data_byte !== want.data) begin
          $display("%0t: data_byte expected %02h, got %02h", $time, want.data, data_byte);
          errors++;
        end
        if (printable !== want.printable) begin
          $display("%0t: printable expected %0b, got %0b (data %02h)",
                   $time, want.printable, printable, want.data);
          errors++;
        end
      end
    end
  end

  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timed out, %0d samples and %0d characters outstanding",
               $time, line_samples.size(), expected_chars.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_level(input logic lvl, input int n);
    repeat (n) begin
      line_samples.push_back(lvl);
      samples_queued++;
    end
  endtask

  // bit length with optional timing error of +/- wobble ticks
  function automatic int bit_ticks(input int len, input int wobble);
    int t;
    t = len + int'($urandom_range(0, 2 * wobble)) - wobble;
    return (t < 1) ? 1 : t;
  endfunction

  task automatic push_char(input logic [ByteW-1:0] b, input int len,
                           input logic stop_lvl, input int wobble);
    push_level(1'b0, bit_ticks(len, wobble));
    for (int i = 0; i < ByteW; i++)
      push_level(b[i], bit_ticks(len, wobble));
    push_level(stop_lvl, bit_ticks(len, wobble));
  endtask

  // random byte, weighted towards the printable boundaries and the extremes
  function automatic logic [ByteW-1:0] pick_char();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0:       return 8'h00;
        1:       return FirstPrintable - 1'b1;
        2:       return FirstPrintable;
        3:       return LastPrintable;
        4:       return LastPrintable + 1'b1;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // samples per line bit for a given period setting
  function automatic int ticks_per_bit(input logic [CountW-1:0] p);
    if (p == 0) return 1 << CountW;   // counter only returns to zero by wrapping
    if (p == 1) return 1;
    return int'(p);
  endfunction

  // sender pause: everything accepted and every expected character back
  task automatic settle();
    while (line_samples.size() != 0 || expected_chars.size() != 0)
      @(posedge clk);
    repeat (DrainTicks) @(posedge clk);
  endtask

  // register write while idle; model follows at the accepting edge
  task automatic write_period(input logic [CountW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    period_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    int len;
    int mark;
    int rand_samples;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one sample per bit. Bad stop bit, all-zero and all-one bytes,
    // the first printable code and the first code past the printable range.
    write_period(12'd1);
    push_level(1'b1, 3);
    push_char(8'h00, 1, 1'b0, 0);
    push_char(8'hFF, 1, 1'b1, 0);
    push_char(FirstPrintable, 1, 1'b1, 0);
    push_char(LastPrintable + 1'b1, 1, 1'b1, 0);
    push_level(1'b1, 11);
    settle();

    // Back-pressure: receiver holds off for a long stretch while characters
    // stream in back to back, so the block fills and stalls its input.
    gap_pct       = 0;
    long_hold_req = 1;
    repeat (16) push_char(pick_char(), 1, 1'b1, 0);
    push_level(1'b1, 11);
    settle();

    // Random phases: mostly well-formed characters with random content and
    // timing error, mixed with bad stop bits, glitches and line noise.
    rand_samples = 0;
    while (rand_samples < RandomSamples) begin
      p = $urandom_range(1, 6);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 8;
        default: gap_pct = 25;
      endcase
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      write_period(CountW'(p));
      len  = ticks_per_bit(CountW'(p));
      mark = samples_queued;
      repeat ($urandom_range(2, 4)) begin
        case ($urandom_range(0, 9))
          7:       push_char(pick_char(), len, 1'b0, 0);           // broken stop bit
          8:       repeat ($urandom_range(1, 3 * len))
                     push_level(1'($urandom_range(0, 1)), 1);      // noise
          9:       push_level(1'b0, $urandom_range(1, len));       // glitch / runt
          default: push_char(pick_char(), len, 1'b1, (len >= 4) ? 1 : 0);
        endcase
        push_level(1'b1, $urandom_range(0, 2 * len));
      end
      // idle long enough to flush any half-built frame
      push_level(1'b1, 11 * len);
      rand_samples += samples_queued - mark;
      settle();
    end

    // Closing stretch: no idling on either side, bit period set to 2.
    gap_pct    = 0;
    stall_pct  = 0;
    gap_left   = 0;
    stall_left = 0;
    write_period(12'd2);
    repeat (8) push_char(pick_char(), 2, 1'b1, 0);
    push_level(1'b1, 22);
    settle();
    repeat (4 * DrainTicks) @(posedge clk);

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
